>>> rtl/slg_pkg.sv
// Shared types and constants for the scaling law loss gap block.
`timescale 1ns / 1ps

package slg_pkg;

    localparam int DIVIDEND_W = 34;
    localparam int DIVISOR_W  = 22;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 22;

    localparam logic [9:0]  LN2_X1000 = 10'd693;
    localparam logic [9:0]  UNIT      = 10'd1000;
    localparam logic [10:0] UNIT_X2   = 11'd2000;
    localparam logic [12:0] UNIT_X6   = 13'd6000;

    localparam logic [CFG_IDX_W-1:0] REG_COEF_A_TERNARY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_TERNARY  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EPS_TERNARY    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A_FLOAT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_FLOAT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_EPS_FLOAT      = 3'd5;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } div_rsp_t;

endpackage

>>> rtl/slg_div.sv
// Radix-4 restoring divider shared by every division of the loss evaluation.
`timescale 1ns / 1ps

module slg_div
    import slg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int STEPS = DIVIDEND_W / 2;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  dsr_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  done_reg;

    logic [DIVISOR_W:0]    sh1;
    logic [DIVISOR_W:0]    sh2;
    logic [DIVISOR_W:0]    r1;
    logic [DIVISOR_W:0]    r2;
    logic                  ge1;
    logic                  ge2;
    logic [DIVIDEND_W-1:0] quo_next;
    logic [DIVISOR_W-1:0]  rem_next;

    always_comb
    begin
        sh1      = {rem_reg, quo_reg[DIVIDEND_W-1]};
        ge1      = (sh1 >= {1'b0, dsr_reg});
        r1       = ge1 ? (sh1 - {1'b0, dsr_reg}) : sh1;
        sh2      = {r1[DIVISOR_W-1:0], quo_reg[DIVIDEND_W-2]};
        ge2      = (sh2 >= {1'b0, dsr_reg});
        r2       = ge2 ? (sh2 - {1'b0, dsr_reg}) : sh2;
        rem_next = r2[DIVISOR_W-1:0];
        quo_next = {quo_reg[DIVIDEND_W-3:0], ge1, ge2};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CNT_W'(1)) && !req.start;
            if (req.start)
            begin
                cnt_reg <= CNT_W'(STEPS);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dsr_reg <= req.divisor;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

>>> rtl/scaling_law_loss_gap_core.sv
// Top level of the scaling law loss gap evaluator with its sequencer.
//
// Channel   Signals                                     Direction
// size      size_valid, size_stall, size_millions       in
// loss      loss_valid, loss_stall, loss_ternary,
//           loss_float, loss_gap                        out
// cfg       cfg_valid, cfg_ready, cfg_index, cfg_data   in
//
// A size beat is taken only once the sequencer is back in idle: each law runs six
// rounds of a multiply step, a divider start and a wait on the shared radix-4
// divider, plus setup and hand-off; a zero exponent leaves one round per law.
// A size of zero skips the rounds. Reset clears the sequencer, the output valid and
// all coefficient registers. A stalled loss beat holds; the next size beat is
// taken meanwhile and is finished into the output register once that is free.
`timescale 1ns / 1ps

module scaling_law_loss_gap_core
    import slg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  size_valid,
    output logic                  size_stall,
    input  logic [15:0]           size_millions,
    output logic                  loss_valid,
    input  logic                  loss_stall,
    output logic [31:0]           loss_ternary,
    output logic [31:0]           loss_float,
    output logic signed [32:0]    loss_gap,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int OPA_W  = 22;
    localparam int OPB_W  = 15;
    localparam int PROD_W = OPA_W + OPB_W;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_LOG   = 8'b0000_0010,
        S_SETUP = 8'b0000_0100,
        S_MUL   = 8'b0000_1000,
        S_DIVGO = 8'b0001_0000,
        S_WAIT  = 8'b0010_0000,
        S_NEXT  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    typedef enum logic [2:0] {
        ST_LN  = 3'd0,
        ST_E   = 3'd1,
        ST_E2  = 3'd2,
        ST_T   = 3'd3,
        ST_E3  = 3'd4,
        ST_QUO = 3'd5
    } step_t;

    state_t state_reg;
    step_t  step_reg;
    logic   law_reg;

    logic [21:0] coef_a_ternary_reg;
    logic [10:0] alpha_ternary_reg;
    logic [15:0] eps_ternary_reg;
    logic [21:0] coef_a_float_reg;
    logic [10:0] alpha_float_reg;
    logic [15:0] eps_float_reg;

    logic [15:0]       n_reg;
    logic [13:0]       log2s_reg;
    logic [13:0]       ln_reg;
    logic [14:0]       e_reg;
    logic [17:0]       e2_reg;
    logic [18:0]       t_reg;
    logic [21:0]       p_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [31:0]       lt_reg;
    logic [31:0]       lf_reg;

    logic               out_valid_reg;
    logic [31:0]        out_t_reg;
    logic [31:0]        out_f_reg;
    logic signed [32:0] out_gap_reg;

    logic [21:0]          a_sel;
    logic [10:0]          alpha_sel;
    logic [15:0]          eps_sel;
    logic [OPA_W-1:0]     opa;
    logic [OPB_W-1:0]     opb;
    logic [DIVISOR_W-1:0] divisor;
    logic [3:0]           k;
    logic [15:0]          lo;
    logic [15:0]          diff;
    logic [25:0]          frac_wide;
    logic [13:0]          log2s;
    logic [21:0]          p_next;
    logic [31:0]          loss_next;
    logic                 out_free;

    div_req_t div_req;
    div_rsp_t div_rsp;

    slg_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_a_ternary_reg <= '0;
            alpha_ternary_reg  <= '0;
            eps_ternary_reg    <= '0;
            coef_a_float_reg   <= '0;
            alpha_float_reg    <= '0;
            eps_float_reg      <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_COEF_A_TERNARY: coef_a_ternary_reg <= cfg_data;
                REG_ALPHA_TERNARY:  alpha_ternary_reg  <= cfg_data[10:0];
                REG_EPS_TERNARY:    eps_ternary_reg    <= cfg_data[15:0];
                REG_COEF_A_FLOAT:   coef_a_float_reg   <= cfg_data;
                REG_ALPHA_FLOAT:    alpha_float_reg    <= cfg_data[10:0];
                REG_EPS_FLOAT:      eps_float_reg      <= cfg_data[15:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        a_sel     = law_reg ? coef_a_float_reg : coef_a_ternary_reg;
        alpha_sel = law_reg ? alpha_float_reg  : alpha_ternary_reg;
        eps_sel   = law_reg ? eps_float_reg    : eps_ternary_reg;
    end

    // Floor of log2 plus the linear fraction of the next octave.
    always_comb
    begin
        k = '0;
        for (int i = 1; i < 16; i++)
        begin
            if (n_reg[i])
            begin
                k = 4'(i);
            end
        end
        lo        = 16'd1 << k;
        diff      = n_reg - lo;
        frac_wide = (26'(diff) * 26'(UNIT)) >> k;
        log2s     = 14'(k) * 14'(UNIT) + frac_wide[13:0];
    end

    always_comb
    begin
        unique case (step_reg)
            ST_LN:
            begin
                opa     = OPA_W'(log2s_reg);
                opb     = OPB_W'(LN2_X1000);
                divisor = DIVISOR_W'(UNIT);
            end
            ST_E:
            begin
                opa     = OPA_W'(alpha_sel);
                opb     = OPB_W'(ln_reg);
                divisor = DIVISOR_W'(UNIT);
            end
            ST_E2:
            begin
                opa     = OPA_W'(e_reg);
                opb     = e_reg;
                divisor = DIVISOR_W'(UNIT_X2);
            end
            ST_T:
            begin
                opa     = OPA_W'(e_reg);
                opb     = e_reg;
                divisor = DIVISOR_W'(UNIT);
            end
            ST_E3:
            begin
                opa     = OPA_W'(t_reg);
                opb     = e_reg;
                divisor = DIVISOR_W'(UNIT_X6);
            end
            ST_QUO:
            begin
                opa     = a_sel;
                opb     = OPB_W'(UNIT);
                divisor = p_reg;
            end
            default:
            begin
                opa     = '0;
                opb     = '0;
                divisor = DIVISOR_W'(UNIT);
            end
        endcase
    end

    always_comb
    begin
        div_req.start    = (state_reg == S_DIVGO);
        div_req.dividend = prod_reg[DIVIDEND_W-1:0];
        div_req.divisor  = divisor;
    end

    assign p_next    = 22'(UNIT) + 22'(e_reg) + 22'(e2_reg) + div_rsp.quotient[21:0];
    assign loss_next = div_rsp.quotient[31:0] + 32'(eps_sel);
    assign out_free  = !out_valid_reg || !loss_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= ST_LN;
            law_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !loss_stall && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (size_valid)
                    begin
                        law_reg   <= 1'b0;
                        state_reg <= S_LOG;
                    end
                end
                S_LOG:
                begin
                    state_reg <= S_SETUP;
                end
                S_SETUP:
                begin
                    priority if (n_reg == '0)
                    begin
                        state_reg <= S_NEXT;
                    end
                    else if (alpha_sel == '0)
                    begin
                        step_reg  <= ST_QUO;
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        step_reg  <= ST_LN;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_DIVGO;
                end
                S_DIVGO:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        unique case (step_reg)
                            ST_LN:   step_reg <= ST_E;
                            ST_E:    step_reg <= ST_E2;
                            ST_E2:   step_reg <= ST_T;
                            ST_T:    step_reg <= ST_E3;
                            ST_E3:   step_reg <= ST_QUO;
                            default: step_reg <= ST_LN;
                        endcase
                        state_reg <= (step_reg == ST_QUO) ? S_NEXT : S_MUL;
                    end
                end
                S_NEXT:
                begin
                    if (law_reg)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        law_reg   <= 1'b1;
                        state_reg <= S_SETUP;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && size_valid)
        begin
            n_reg <= size_millions;
        end
        if (state_reg == S_LOG)
        begin
            log2s_reg <= log2s;
        end
        if (state_reg == S_SETUP)
        begin
            p_reg <= 22'(UNIT);
            if (n_reg == '0)
            begin
                if (law_reg)
                begin
                    lf_reg <= 32'(eps_sel);
                end
                else
                begin
                    lt_reg <= 32'(eps_sel);
                end
            end
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= PROD_W'(opa) * PROD_W'(opb);
        end
        if (state_reg == S_WAIT && div_rsp.done)
        begin
            unique case (step_reg)
                ST_LN:  ln_reg <= div_rsp.quotient[13:0];
                ST_E:   e_reg  <= div_rsp.quotient[14:0];
                ST_E2:  e2_reg <= div_rsp.quotient[17:0];
                ST_T:   t_reg  <= div_rsp.quotient[18:0];
                ST_E3:  p_reg  <= p_next;
                ST_QUO:
                begin
                    if (law_reg)
                    begin
                        lf_reg <= loss_next;
                    end
                    else
                    begin
                        lt_reg <= loss_next;
                    end
                end
                default: ;
            endcase
        end
        if (state_reg == S_DONE && out_free)
        begin
            out_t_reg   <= lt_reg;
            out_f_reg   <= lf_reg;
            out_gap_reg <= $signed({1'b0, lt_reg}) - $signed({1'b0, lf_reg});
        end
    end

    assign size_stall   = (state_reg != S_IDLE);
    assign loss_valid   = out_valid_reg;
    assign loss_ternary = out_t_reg;
    assign loss_float   = out_f_reg;
    assign loss_gap     = out_gap_reg;

    // The gap beat always agrees with the two losses it travels with.
    a_gap_matches: assert property (@(posedge clk) disable iff (!rst_n)
        loss_valid |-> (loss_gap == ($signed({1'b0, loss_ternary})
                                     - $signed({1'b0, loss_float}))))
        else $error("loss_gap does not match the two losses");

    // The divider only finishes while the sequencer waits for it.
    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_WAIT))
        else $error("divider finished outside the wait state");

    // The final division never sees a power below one.
    a_power_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (div_req.start && step_reg == ST_QUO) |-> (p_reg >= 22'(UNIT)))
        else $error("power below one reached the final division");

    // A size beat always closes the input side for the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (size_valid && !size_stall) |=> size_stall)
        else $error("input accepted twice in a row");

endmodule

>>> tb/scaling_law_loss_gap_core_test.sv
// Self-checking testbench for the scaling law loss gap core.
`timescale 1ns / 1ps

module scaling_law_loss_gap_core_test
    import slg_pkg::*;
();

    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int RANDOM_PHASES = 12;
    localparam int SIZES_PER_PHASE = 120;
    localparam int DRAIN_CYCLES = 300;
    localparam longint unsigned POWER_CEILING = 64'h7FFF_FFFF;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [31:0]        ternary_loss;
        logic [31:0]        float_loss;
        logic signed [32:0] gap;
    } loss_beat_t;

    typedef struct {
        bit                    is_write;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
        logic [15:0]           size;
        bit                    typed;
        loss_beat_t            want;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  size_valid = 1'b0;
    logic                  size_stall;
    logic [15:0]           size_millions = '0;
    logic                  loss_valid;
    logic                  loss_stall = 1'b0;
    logic [31:0]           loss_ternary;
    logic [31:0]           loss_float;
    logic signed [32:0]    loss_gap;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic [21:0] coef_a_t, coef_a_f;
    logic [10:0] alpha_t, alpha_f;
    logic [15:0] eps_t, eps_f;

    loss_beat_t pending_losses[$];
    loss_beat_t oldest_loss;
    stim_row_t  directed_rows[$];

    int errors = 0;
    int cycles = 0;
    int sizes_sent = 0;
    int losses_checked = 0;
    int settings_used = 1;
    int burst_left = 0;
    int stall_left = 0;
    int free_left = 0;

    scaling_law_loss_gap_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .size_valid    (size_valid),
        .size_stall    (size_stall),
        .size_millions (size_millions),
        .loss_valid    (loss_valid),
        .loss_stall    (loss_stall),
        .loss_ternary  (loss_ternary),
        .loss_float    (loss_float),
        .loss_gap      (loss_gap),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic longint unsigned ln_x1000(input longint unsigned n);
        longint unsigned k, t, lo, frac;
        if (n <= 1) return 0;
        k = 0;
        t = n;
        while (t > 1)
        begin
            t = t >> 1;
            k++;
        end
        lo = 64'd1 << k;
        frac = ((n - lo) * UNIT) / lo;
        return ((k * UNIT + frac) * LN2_X1000) / UNIT;
    endfunction

    function automatic longint unsigned power_x1000(input longint unsigned n,
                                                    input longint unsigned alpha);
        longint unsigned e, e2, e3, r;
        if (alpha == 0) return UNIT;
        e = (alpha * ln_x1000(n)) / UNIT;
        e2 = (e * e) / UNIT_X2;
        e3 = ((e * e) / UNIT * e) / UNIT_X6;
        r = UNIT + e + e2 + e3;
        if (r > POWER_CEILING) r = POWER_CEILING;
        return r;
    endfunction

    function automatic longint unsigned law_loss_x1000(input longint unsigned n,
                                                       input longint unsigned a,
                                                       input longint unsigned alpha,
                                                       input longint unsigned eps);
        longint unsigned p;
        if (n == 0) return eps;
        p = power_x1000(n, alpha);
        if (p == 0) p = 1;
        return (a * UNIT) / p + eps;
    endfunction

    function automatic loss_beat_t predict_losses(input logic [15:0] n);
        longint unsigned lt, lf, diff;
        loss_beat_t beat;
        lt = law_loss_x1000(n, coef_a_t, alpha_t, eps_t);
        lf = law_loss_x1000(n, coef_a_f, alpha_f, eps_f);
        diff = lt - lf;
        beat.ternary_loss = lt[31:0];
        beat.float_loss = lf[31:0];
        beat.gap = diff[32:0];
        return beat;
    endfunction

    function automatic void store_coefficient(input logic [CFG_IDX_W-1:0] idx,
                                              input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_COEF_A_TERNARY: coef_a_t = data[21:0];
            REG_ALPHA_TERNARY:  alpha_t = data[10:0];
            REG_EPS_TERNARY:    eps_t = data[15:0];
            REG_COEF_A_FLOAT:   coef_a_f = data[21:0];
            REG_ALPHA_FLOAT:    alpha_f = data[10:0];
            REG_EPS_FLOAT:      eps_f = data[15:0];
            default: ;
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_coefficient(input logic [CFG_IDX_W-1:0] idx);
        logic [CFG_DATA_W-1:0] top;
        case (idx)
            REG_ALPHA_TERNARY, REG_ALPHA_FLOAT: top = 22'd2000;
            REG_EPS_TERNARY, REG_EPS_FLOAT:     top = 22'd65535;
            default:                            top = 22'd2147483;
        endcase
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return top;
            3:       return 22'($urandom);
            default: return 22'($urandom_range(top));
        endcase
    endfunction

    function automatic logic [15:0] random_size();
        int unsigned sh;
        sh = $urandom_range(15);
        case ($urandom_range(9))
            0:       return 16'($urandom_range(3));
            1:       return 16'((32'd1 << sh) + $urandom_range(2) - 1);
            2:       return 16'(65535 - $urandom_range(3));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        stim_row_t row;
        row.is_write = 1'b1;
        row.index = idx;
        row.data = data;
        row.size = '0;
        row.typed = 1'b0;
        row.want = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_size(input logic [15:0] n, input bit typed,
                                     input logic [31:0] lt, input logic [31:0] lf,
                                     input logic signed [32:0] gap);
        stim_row_t row;
        row.is_write = 1'b0;
        row.index = '0;
        row.data = '0;
        row.size = n;
        row.typed = typed;
        row.want.ternary_loss = lt;
        row.want.float_loss = lf;
        row.want.gap = gap;
        directed_rows.push_back(row);
    endfunction

    task automatic write_coefficient(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        store_coefficient(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cfg_data <= 22'($urandom);
    endtask

    task automatic send_size(input logic [15:0] n, input bit typed, input loss_beat_t want);
        @(negedge clk);
        size_valid <= 1'b1;
        size_millions <= n;
        @(posedge clk);
        while (size_stall) @(posedge clk);
        pending_losses.push_back(typed ? want : predict_losses(n));
        sizes_sent++;
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(30, 1);
            case ($urandom_range(3))
                0:       gap = 0;
                1:       gap = $urandom_range(400, 20);
                default: gap = $urandom_range(12, 1);
            endcase
            repeat (gap)
            begin
                @(negedge clk);
                size_valid <= 1'b0;
                size_millions <= 16'($urandom);
            end
        end
        burst_left--;
    endtask

    task automatic drain_losses();
        @(negedge clk);
        size_valid <= 1'b0;
        while (pending_losses.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            loss_stall <= 1'b1;
            stall_left--;
        end
        else if (free_left > 0)
        begin
            loss_stall <= 1'b0;
            free_left--;
        end
        else
        begin
            loss_stall <= 1'b0;
            case ($urandom_range(3))
                0:
                begin
                    stall_left = 0;
                    free_left = $urandom_range(400, 50);
                end
                1:
                begin
                    stall_left = $urandom_range(3, 1);
                    free_left = $urandom_range(4);
                end
                2:
                begin
                    stall_left = $urandom_range(40, 4);
                    free_left = $urandom_range(20, 1);
                end
                default:
                begin
                    stall_left = $urandom_range(10, 1);
                    free_left = $urandom_range(10, 1);
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && loss_valid && !loss_stall)
        begin
            if (pending_losses.size() == 0)
            begin
                $display("%0t: loss beat with no size pending: ternary %0d float %0d gap %0d",
                         $time, loss_ternary, loss_float, loss_gap);
                errors++;
            end
            else
            begin
                oldest_loss = pending_losses.pop_front();
                losses_checked++;
                if (loss_ternary !== oldest_loss.ternary_loss)
                begin
                    $display("%0t: loss_ternary expected %0d got %0d",
                             $time, oldest_loss.ternary_loss, loss_ternary);
                    errors++;
                end
                if (loss_float !== oldest_loss.float_loss)
                begin
                    $display("%0t: loss_float expected %0d got %0d",
                             $time, oldest_loss.float_loss, loss_float);
                    errors++;
                end
                if (loss_gap !== oldest_loss.gap)
                begin
                    $display("%0t: loss_gap expected %0d got %0d",
                             $time, oldest_loss.gap, loss_gap);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("scaling_law_loss_gap_core regression: fail");
            $finish;
        end
    end

    initial
    begin
        logic [CFG_IDX_W-1:0] reg_order[6];
        stim_row_t row;
        bit last_was_write;

        reg_order = '{REG_COEF_A_TERNARY, REG_ALPHA_TERNARY, REG_EPS_TERNARY,
                      REG_COEF_A_FLOAT, REG_ALPHA_FLOAT, REG_EPS_FLOAT};
        coef_a_t = '0;
        alpha_t = '0;
        eps_t = '0;
        coef_a_f = '0;
        alpha_f = '0;
        eps_f = '0;
        last_was_write = 1'b0;

        // Reset values first, then each law alone at full scale, then typical coefficients.
        add_size(16'd0, 1, 32'd0, 32'd0, 33'sd0);
        add_size(16'd65535, 1, 32'd0, 32'd0, 33'sd0);
        add_size(16'd1, 1, 32'd0, 32'd0, 33'sd0);
        add_write(REG_COEF_A_TERNARY, 22'h3FFFFF);
        add_write(REG_ALPHA_TERNARY, 22'd0);
        add_write(REG_EPS_TERNARY, 22'h00FFFF);
        add_write(REG_COEF_A_FLOAT, 22'd0);
        add_write(REG_ALPHA_FLOAT, 22'h3FFFFF);
        add_write(REG_EPS_FLOAT, 22'd0);
        add_size(16'd0, 1, 32'd65535, 32'd0, 33'sd65535);
        add_size(16'd1, 1, 32'd4259838, 32'd0, 33'sd4259838);
        add_size(16'd65535, 1, 32'd4259838, 32'd0, 33'sd4259838);
        add_size(16'd2, 0, '0, '0, '0);
        add_size(16'd32768, 0, '0, '0, '0);
        add_write(REG_COEF_A_TERNARY, 22'd0);
        add_write(REG_ALPHA_TERNARY, 22'h3FFFFF);
        add_write(REG_EPS_TERNARY, 22'd0);
        add_write(REG_COEF_A_FLOAT, 22'h3FFFFF);
        add_write(REG_ALPHA_FLOAT, 22'd0);
        add_write(REG_EPS_FLOAT, 22'h00FFFF);
        add_write(REG_SPARE_6, 22'h3FFFFF);
        add_write(REG_SPARE_7, 22'h155555);
        add_size(16'd0, 1, 32'd0, 32'd65535, -33'sd65535);
        add_size(16'd1, 1, 32'd0, 32'd4259838, -33'sd4259838);
        add_size(16'd65535, 1, 32'd0, 32'd4259838, -33'sd4259838);
        add_size(16'd3, 0, '0, '0, '0);
        add_size(16'd4097, 0, '0, '0, '0);
        add_write(REG_COEF_A_TERNARY, 22'd406);
        add_write(REG_ALPHA_TERNARY, 22'd340);
        add_write(REG_EPS_TERNARY, 22'd1690);
        add_write(REG_COEF_A_FLOAT, 22'd410);
        add_write(REG_ALPHA_FLOAT, 22'h200118);
        add_write(REG_EPS_FLOAT, 22'd1820);
        add_size(16'd7, 0, '0, '0, '0);
        add_size(16'd100, 0, '0, '0, '0);
        add_size(16'd1000, 0, '0, '0, '0);
        add_size(16'd12345, 0, '0, '0, '0);
        add_size(16'd65534, 0, '0, '0, '0);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.is_write)
            begin
                if (!last_was_write)
                begin
                    drain_losses();
                    settings_used++;
                end
                write_coefficient(row.index, row.data);
            end
            else
            begin
                send_size(row.size, row.typed, row.want);
            end
            last_was_write = row.is_write;
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain_losses();
            foreach (reg_order[r])
                write_coefficient(reg_order[r], random_coefficient(reg_order[r]));
            if ($urandom_range(3) == 0)
                write_coefficient($urandom_range(1) ? REG_SPARE_6 : REG_SPARE_7,
                                  22'($urandom));
            settings_used++;
            for (int k = 0; k < SIZES_PER_PHASE; k++)
            begin
                if ($urandom_range(199) == 0)
                    drain_losses();
                pace_sender();
                send_size(random_size(), 0, '0);
            end
        end

        @(negedge clk);
        size_valid <= 1'b0;
        while (pending_losses.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_losses.size() != 0)
        begin
            $display("%0t: %0d loss beats never arrived", $time, pending_losses.size());
            errors++;
        end

        $display("Sent %0d size beats and checked %0d loss beats across %0d coefficient settings.",
                 sizes_sent, losses_checked, settings_used);
        $display("Sizes spanned zero, one, powers of two and full scale; %0d mismatches seen.",
                 errors);
        if (errors == 0)
            $display("scaling_law_loss_gap_core regression: pass");
        else
            $display("scaling_law_loss_gap_core regression: fail");
        $finish;
    end

endmodule
